// File: rtl/swpf_pkg.sv
`timescale 1ns / 1ps

package swpf_pkg;

    // Opcodes of an input item.
    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // Sync word after reset.
    localparam logic [31:0] SYNC_RESET = 32'hDEAD_BEEF;

    // Largest number of bytes that one input item can cause.
    localparam int unsigned BURST_MAX = 8;
    localparam int unsigned CNT_W     = 4;

    // Header bytes of a frame with a payload: sync word, type, length low, length high.
    localparam logic [CNT_W-1:0] HDR_BYTES = 4'd7;
    // Header plus checksum, for a zero-length packet.
    localparam logic [CNT_W-1:0] HDR_CHK_BYTES = 4'd8;
    // Last payload byte plus checksum.
    localparam logic [CNT_W-1:0] LAST_BYTES = 4'd2;
    localparam logic [CNT_W-1:0] ONE_BYTE   = 4'd1;
    localparam logic [CNT_W-1:0] NO_BYTES   = 4'd0;

    // One input item.
    typedef struct packed {
        logic        opcode;
        logic [7:0]  packet_type;
        logic [15:0] packet_length;
        logic [7:0]  payload_byte;
    } t_in_item;

    // One output item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       run_end;
    } t_out_item;

    // The bytes that one input item causes, oldest in slot 0.
    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic                      ends_frame;
    } t_burst;

endpackage

// File: rtl/sync_word_packet_framer.sv
`timescale 1ns / 1ps

// Frame builder: a start item (opcode 0) sends the four sync word bytes, most significant
// first, then the packet type and the length low and high bytes, and seeds an XOR checksum
// with those three; each payload item (opcode 1) of an open packet is passed through and
// folded into the checksum, and the checksum byte, marked by frame_end, follows the last
// counted payload byte (at once after the header for a zero-length packet). run_end marks the
// last byte caused by each item; a payload item with no open packet causes nothing, and a new
// start abandons an open packet. Bytes leave one per cycle on a single output lane while the
// receiver does not stall. A payload item causes one byte (two for the last of a packet) and
// a start item seven (eight when the length is zero); the next item is taken in the same cycle
// as the last byte of the previous one leaves. The sync word may only be written while no
// output is pending.
module sync_word_packet_framer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  swpf_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output swpf_pkg::t_out_item o_item,
    input  logic                i_cfg_wr_en,
    input  logic [31:0]         i_cfg_wr_data
);
    import swpf_pkg::*;

    t_burst w_burst;
    logic   w_ready;
    logic   w_accept;

    assign o_stall  = !w_ready;
    assign w_accept = i_valid && w_ready;

    // Packet state and burst assembly.
    swpf_build u_build (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_item        (i_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_burst       (w_burst)
    );

    // Output register, one output item per byte of each burst.
    swpf_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_burst (w_burst),
        .o_ready (w_ready),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

endmodule

// File: rtl/swpf_build.sv
`timescale 1ns / 1ps

module swpf_build (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  swpf_pkg::t_in_item i_item,
    input  logic               i_cfg_wr_en,
    input  logic [31:0]        i_cfg_wr_data,
    output swpf_pkg::t_burst   o_burst
);
    import swpf_pkg::*;

    logic [31:0] r_sync_word;
    logic [15:0] r_bytes_left;
    logic [15:0] n_bytes_left;
    logic [7:0]  r_running_check;
    logic [7:0]  n_running_check;
    logic        r_frame_open;
    logic        n_frame_open;

    logic [7:0]  w_len_lo;
    logic [7:0]  w_len_hi;
    logic [7:0]  w_seed;
    logic        w_empty;
    logic [7:0]  w_check_upd;
    logic        w_last;

    assign w_len_lo    = i_item.packet_length[7:0];
    assign w_len_hi    = i_item.packet_length[15:8];
    assign w_seed      = i_item.packet_type ^ w_len_lo ^ w_len_hi;
    assign w_empty     = (i_item.packet_length == 16'd0);
    assign w_check_upd = r_running_check ^ i_item.payload_byte;
    assign w_last      = (r_bytes_left == 16'd1);

    // Work out the bytes of this item and the packet state it leaves behind.
    always_comb begin
        o_burst         = '0;
        n_bytes_left    = r_bytes_left;
        n_running_check = r_running_check;
        n_frame_open    = r_frame_open;
        priority if (i_item.opcode == OP_START) begin
            o_burst.bytes      = {w_seed, w_len_hi, w_len_lo, i_item.packet_type,
                                  r_sync_word[7:0], r_sync_word[15:8],
                                  r_sync_word[23:16], r_sync_word[31:24]};
            o_burst.count      = w_empty ? HDR_CHK_BYTES : HDR_BYTES;
            o_burst.ends_frame = w_empty;
            n_bytes_left       = i_item.packet_length;
            n_running_check    = w_empty ? 8'd0 : w_seed;
            n_frame_open       = !w_empty;
        end else if (r_frame_open) begin
            o_burst.bytes[0]   = i_item.payload_byte;
            o_burst.bytes[1]   = w_check_upd;
            o_burst.count      = w_last ? LAST_BYTES : ONE_BYTE;
            o_burst.ends_frame = w_last;
            n_bytes_left       = r_bytes_left - 16'd1;
            n_running_check    = w_last ? 8'd0 : w_check_upd;
            n_frame_open       = !w_last;
        end else begin
            // A payload item with no open packet leaves everything as it is.
            o_burst.count = NO_BYTES;
        end
    end

    // Packet state advances on every accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left    <= '0;
            r_running_check <= '0;
            r_frame_open    <= 1'b0;
        end else if (i_accept) begin
            r_bytes_left    <= n_bytes_left;
            r_running_check <= n_running_check;
            r_frame_open    <= n_frame_open;
        end
    end

    // Sync word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_word <= SYNC_RESET;
        end else if (i_cfg_wr_en) begin
            r_sync_word <= i_cfg_wr_data;
        end
    end

    // An open packet always has payload bytes still to come.
    a_open_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_open |-> (r_bytes_left != 16'd0))
        else $error("open packet with no payload bytes left");

    // A closed packet carries no stale checksum into the next frame.
    a_closed_check_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_frame_open |-> (r_running_check == 8'd0))
        else $error("checksum not cleared after the packet closed");

endmodule

// File: rtl/swpf_ser.sv
`timescale 1ns / 1ps

module swpf_ser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  swpf_pkg::t_burst    i_burst,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_stall,
    output swpf_pkg::t_out_item o_item
);
    import swpf_pkg::*;

    logic [BURST_MAX-1:0][7:0] r_bytes;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_ends_frame;
    logic                      w_take;
    logic                      w_last;

    assign w_last  = (r_cnt == ONE_BYTE);
    assign o_valid = (r_cnt != NO_BYTES);
    assign w_take  = o_valid && !i_stall;
    // A new burst may load as the last byte of the present one leaves.
    assign o_ready = !o_valid || (w_last && !i_stall);

    assign o_item.out_byte  = r_bytes[0];
    assign o_item.run_end   = w_last;
    assign o_item.frame_end = w_last && r_ends_frame;

    // Byte count of the burst held for output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= NO_BYTES;
        end else if (i_accept && (i_burst.count != NO_BYTES)) begin
            r_cnt <= i_burst.count;
        end else if (w_take) begin
            r_cnt <= r_cnt - ONE_BYTE;
        end
    end

    // Burst bytes, shifted down one slot for every item taken.
    always_ff @(posedge i_clk) begin
        if (i_accept && (i_burst.count != NO_BYTES)) begin
            r_bytes      <= i_burst.bytes;
            r_ends_frame <= i_burst.ends_frame;
        end else if (w_take) begin
            r_bytes <= {8'd0, r_bytes[BURST_MAX-1:1]};
        end
    end

    // No new burst can load while more than one byte of the present one waits.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > ONE_BYTE) |-> !o_ready)
        else $error("input accepted while a burst is still being sent");

    // Each byte taken from a longer burst leaves one fewer behind.
    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_cnt > ONE_BYTE) && !i_stall) |=> (r_cnt == $past(r_cnt) - ONE_BYTE))
        else $error("burst count did not step down");

    // A stalled burst keeps its count.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (r_cnt == $past(r_cnt)))
        else $error("burst count changed under stall");

endmodule

// File: tb/sv/sync_word_packet_framer_test.sv
`timescale 1ns / 1ps

module sync_word_packet_framer_test;

    import swpf_pkg::*;

    // Cycles to let pass once the last expected byte has gone, and the idle limit.
    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT   = 4000;
    localparam int DIR_ROWS      = 23;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 96;

    // One row of the directed table. Where typed is set, the expected bytes are given in
    // wire order from the top of bytes, and bit 7 of the masks belongs to the first byte.
    typedef struct packed {
        t_in_item    item;
        logic        typed;
        logic [3:0]  n_res;
        logic [63:0] bytes;
        logic [7:0]  fend;
        logic [7:0]  rend;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    t_in_item    i_item        = '0;
    logic        i_stall       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [31:0] i_cfg_wr_data = '0;
    logic        o_stall;
    logic        o_valid;
    t_out_item   o_item;

    // The row that travels with the item on the input channel.
    t_dir_row cur_row = '0;

    // Framer state as predicted.
    logic [31:0] tx_sync  = SYNC_RESET;
    logic [15:0] tx_left  = '0;
    logic [7:0]  tx_check = '0;
    logic        tx_open  = 1'b0;

    t_out_item burst_q[$];
    t_out_item wire_bytes_q[$];

    int fail_count     = 0;
    int quiet_cycles   = 0;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;

    t_dir_row dir_table [DIR_ROWS];

    sync_word_packet_framer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_item        (i_item),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_item        (o_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_out_item wire_byte(logic [7:0] b, logic fe, logic re);
        t_out_item o;
        o.out_byte  = b;
        o.frame_end = fe;
        o.run_end   = re;
        return o;
    endfunction

    function automatic t_in_item mk_item(logic op, logic [7:0] ptype, logic [15:0] plen,
                                         logic [7:0] pbyte);
        t_in_item it;
        it.opcode        = op;
        it.packet_type   = ptype;
        it.packet_length = plen;
        it.payload_byte  = pbyte;
        return it;
    endfunction

    // Works out the bytes that one item puts on the wire and advances the framer state.
    function automatic void frame_step(t_in_item it);
        logic [7:0] lo;
        logic [7:0] hi;
        int i;
        burst_q.delete();
        if (it.opcode == OP_START) begin
            lo = it.packet_length[7:0];
            hi = it.packet_length[15:8];
            for (i = 0; i < 4; i++) begin
                burst_q.push_back(wire_byte(tx_sync[31 - 8 * i -: 8], 1'b0, 1'b0));
            end
            burst_q.push_back(wire_byte(it.packet_type, 1'b0, 1'b0));
            burst_q.push_back(wire_byte(lo, 1'b0, 1'b0));
            burst_q.push_back(wire_byte(hi, 1'b0, it.packet_length != 16'd0));
            tx_check = it.packet_type ^ lo ^ hi;
            tx_left  = it.packet_length;
            if (it.packet_length == 16'd0) begin
                burst_q.push_back(wire_byte(tx_check, 1'b1, 1'b1));
                tx_open  = 1'b0;
                tx_check = '0;
            end else begin
                tx_open = 1'b1;
            end
        end else if (tx_open) begin
            tx_check = tx_check ^ it.payload_byte;
            tx_left  = tx_left - 16'd1;
            if (tx_left == 16'd0) begin
                burst_q.push_back(wire_byte(it.payload_byte, 1'b0, 1'b0));
                burst_q.push_back(wire_byte(tx_check, 1'b1, 1'b1));
                tx_open  = 1'b0;
                tx_check = '0;
            end else begin
                burst_q.push_back(wire_byte(it.payload_byte, 1'b0, 1'b1));
            end
        end
    endfunction

    task automatic report_mismatch(string what);
        fail_count++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // Offers one item until it is taken, then perhaps leaves the channel idle for a while.
    task automatic send_row(t_dir_row r);
        i_valid <= 1'b1;
        i_item  <= r.item;
        cur_row <= r;
        do @(posedge i_clk); while (o_stall);
        if ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic send_item(t_in_item it);
        t_dir_row r;
        r      = '0;
        r.item = it;
        send_row(r);
    endtask

    // Holds the input back until every expected byte has gone and the block has settled.
    task automatic drain_frames();
        i_valid <= 1'b0;
        while (wire_bytes_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_sync(logic [31:0] word);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= word;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Mostly whole packets with random content; some cut short, some huge and abandoned,
    // and some stray payload bytes as noise.
    task automatic send_random_frames(int count);
        int sent;
        int len;
        int nsend;
        int j;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 3) begin
                drain_frames();
            end
            if ($urandom_range(99) < 82) begin
                j = $urandom_range(99);
                if (j < 12) begin
                    len = 0;
                end else if (j < 18) begin
                    len = $urandom_range(65535);
                end else begin
                    len = $urandom_range(1, 8);
                end
                send_item(mk_item(OP_START, 8'($urandom_range(255)), 16'(len),
                                  8'($urandom_range(255))));
                sent++;
                if (len > 8) begin
                    nsend = $urandom_range(0, 6);
                end else if (len > 0 && $urandom_range(99) < 10) begin
                    nsend = $urandom_range(0, len - 1);
                end else begin
                    nsend = len;
                end
                for (j = 0; j < nsend; j++) begin
                    send_item(mk_item(OP_PAYLOAD, 8'($urandom_range(255)),
                                      16'($urandom_range(65535)), 8'($urandom_range(255))));
                    sent++;
                end
            end else begin
                nsend = $urandom_range(1, 3);
                for (j = 0; j < nsend; j++) begin
                    send_item(mk_item(OP_PAYLOAD, 8'($urandom_range(255)),
                                      16'($urandom_range(65535)), 8'($urandom_range(255))));
                    sent++;
                end
            end
        end
    endtask

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        i_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // Samples both channels and the register port at each edge, predicting and checking.
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        logic busy;
        int k;
        busy = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_wr_en) begin
                tx_sync = i_cfg_wr_data;
            end
            if (i_valid && !o_stall) begin
                busy = 1'b1;
                frame_step(i_item);
                if (cur_row.typed) begin
                    for (k = 0; k < int'(cur_row.n_res); k++) begin
                        wire_bytes_q.push_back(wire_byte(cur_row.bytes[63 - 8 * k -: 8],
                                                         cur_row.fend[7 - k],
                                                         cur_row.rend[7 - k]));
                    end
                end else begin
                    foreach (burst_q[m]) wire_bytes_q.push_back(burst_q[m]);
                end
            end
            if (o_valid && !i_stall) begin
                busy = 1'b1;
                if (wire_bytes_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h", o_item.out_byte));
                end else begin
                    want = wire_bytes_q.pop_front();
                    if (o_item.out_byte !== want.out_byte) begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  o_item.out_byte, want.out_byte));
                    end
                    if (o_item.frame_end !== want.frame_end) begin
                        report_mismatch($sformatf("frame_end %b, expected %b",
                                                  o_item.frame_end, want.frame_end));
                    end
                    if (o_item.run_end !== want.run_end) begin
                        report_mismatch($sformatf("run_end %b, expected %b",
                                                  o_item.run_end, want.run_end));
                    end
                end
            end
        end
        quiet_cycles = busy ? 0 : quiet_cycles + 1;
    end

    // Ends a run in which neither channel moves for too long.
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("sync_word_packet_framer verification failed");
        $finish;
    end

    // Directed items, all under the sync word after reset.
    initial begin
        dir_table = '{
            // Stray payload byte right after reset.
            '{'{OP_PAYLOAD, 8'hFF, 16'hFFFF, 8'hFF}, 1'b1, 4'd0, 64'd0, 8'h00, 8'h00},
            // Zero-length packet: header then checksum equal to the type.
            '{'{OP_START, 8'h5A, 16'h0000, 8'hFF}, 1'b1, 4'd8,
              64'hDEADBEEF_5A00005A, 8'h01, 8'h01},
            // Largest type and length.
            '{'{OP_START, 8'hFF, 16'hFFFF, 8'hAA}, 1'b1, 4'd7,
              64'hDEADBEEF_FFFFFF00, 8'h00, 8'h02},
            '{'{OP_PAYLOAD, 8'h00, 16'h0000, 8'h00}, 1'b0, 4'd0, 64'd0, 8'h00, 8'h00},
            '{'{OP_PAYLOAD, 8'h00, 16'h0000, 8'hFF}, 1'b0, 4'd0, 64'd0, 8'h00, 8'h00},
            // Restart abandons the open packet.
            '{'{OP_START, 8'h00, 16'h0001, 8'h00}, 1'b1, 4'd7,
              64'hDEADBEEF_00010000, 8'h00, 8'h02},
            // Last payload byte, then the checksum.
            '{'{OP_PAYLOAD, 8'hFF, 16'hFFFF, 8'h80}, 1'b1, 4'd2,
              64'h8081_0000_0000_0000, 8'h40, 8'h40},
            '{'{OP_PAYLOAD, 8'h00, 16'h0000, 8'h00}, 1'b1, 4'd0, 64'd0, 8'h00, 8'h00},
            '{'{OP_START, 8'h12, 16'h0003, 8'h00}, 1'b0, 4'd0, 64'd0, 8'h00, 8'h00},
            '{'{OP_PAYLOAD, 8'h00, 16'h0000, 8'h34}, 1'b0, 4'd0, 64'd0, 8'h00, 8'h00},
            '{'{OP_PAYLOAD, 8'h00, 16'h0000, 8'h56}, 1'b0, 4'd0, 64'd0, 8'h00, 8'h00},
            '{'{OP_PAYLOAD, 8'h00, 16'h0000, 8'h78}, 1'b0, 4'd0, 64'd0, 8'h00, 8'h00},
            '{'{OP_START, 8'hC3, 16'h0100, 8'h55}, 1'b0, 4'd0, 64'd0, 8'h00, 8'h00},
            '{'{OP_PAYLOAD, 8'h00, 16'h0000, 8'h01}, 1'b0, 4'd0, 64'd0, 8'h00, 8'h00},
            '{'{OP_PAYLOAD, 8'h00, 16'h0000, 8'hFE}, 1'b0, 4'd0, 64'd0, 8'h00, 8'h00},
            '{'{OP_START, 8'h7E, 16'h8000, 8'h00}, 1'b0, 4'd0, 64'd0, 8'h00, 8'h00},
            '{'{OP_PAYLOAD, 8'h00, 16'h0000, 8'hAA}, 1'b0, 4'd0, 64'd0, 8'h00, 8'h00},
            // Zero-length start over an open packet.
            '{'{OP_START, 8'h00, 16'h0000, 8'h00}, 1'b1, 4'd8,
              64'hDEADBEEF_00000000, 8'h01, 8'h01},
            '{'{OP_PAYLOAD, 8'h00, 16'h0000, 8'h5A}, 1'b1, 4'd0, 64'd0, 8'h00, 8'h00},
            '{'{OP_START, 8'hA5, 16'h0002, 8'h00}, 1'b0, 4'd0, 64'd0, 8'h00, 8'h00},
            '{'{OP_PAYLOAD, 8'h00, 16'h0000, 8'hFF}, 1'b0, 4'd0, 64'd0, 8'h00, 8'h00},
            '{'{OP_PAYLOAD, 8'h00, 16'h0000, 8'h00}, 1'b0, 4'd0, 64'd0, 8'h00, 8'h00},
            '{'{OP_PAYLOAD, 8'hFF, 16'hFFFF, 8'hFF}, 1'b0, 4'd0, 64'd0, 8'h00, 8'h00}
        };
    end

    // Reset, directed table, then random phases under several sync words and idling mixes.
    initial begin
        int r;
        int p;
        logic [31:0] word;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < DIR_ROWS; r++) begin
            send_row(dir_table[r]);
        end
        drain_frames();

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    word = 32'h0000_0000;
                    send_gap_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    word = 32'hFFFF_FFFF;
                    send_gap_pct = 46;
                    recv_stall_pct = 0;
                end
                2: begin
                    word = $urandom;
                    send_gap_pct = 0;
                    recv_stall_pct = 46;
                end
                3: begin
                    word = $urandom;
                    send_gap_pct = 18;
                    recv_stall_pct = 18;
                end
                default: begin
                    word = SYNC_RESET;
                    send_gap_pct = 46;
                    recv_stall_pct = 46;
                end
            endcase
            write_sync(word);
            send_random_frames(PHASE_ITEMS);
            drain_frames();
        end

        if (wire_bytes_q.size() != 0) begin
            report_mismatch($sformatf("%0d expected bytes never came", wire_bytes_q.size()));
        end
        if (fail_count == 0) begin
            $display("sync_word_packet_framer verification clean");
        end else begin
            $display("sync_word_packet_framer verification failed");
        end
        $finish;
    end

endmodule

// File: sync_word_packet_framer.f
rtl/swpf_pkg.sv
rtl/swpf_build.sv
rtl/swpf_ser.sv
rtl/sync_word_packet_framer.sv
tb/sv/sync_word_packet_framer_test.sv
